@@ rtl/mtm_pkg.sv @@
// Shared constants, types and helpers for the memory-to-memory ALU executor.
// No dependencies; imported by the top level.
package mtm_pkg;

    localparam int MEMORY_WORDS        = 32768;
    localparam int MEM_AW              = $clog2(MEMORY_WORDS);
    localparam int STACK_POINTER_INDEX = 1;
    localparam int REG_COUNT           = 8;
    localparam int REG_AW              = 3;
    localparam int WORD_W              = 32;
    localparam int OFF_W               = 9;
    localparam int HADDR_W             = 15;
    localparam int INDEX_W             = 15;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_COPY      = 4'd2,
        OP_AND       = 4'd3,
        OP_OR        = 4'd4,
        OP_NOR       = 4'd5,
        OP_XOR       = 4'd6,
        OP_LOADREG   = 4'd7,
        OP_STOREREG  = 4'd8,
        OP_STOREADDR = 4'd9,
        OP_INDIRECT  = 4'd10,
        OP_NEGATE    = 4'd11,
        OP_HOSTMEM   = 4'd12,
        OP_HOSTREG   = 4'd13
    } t_op;

    typedef struct packed {
        logic [3:0]         operation;
        logic [REG_AW-1:0]  target_reg;
        logic [OFF_W-1:0]   target_offset;
        logic [REG_AW-1:0]  source_reg;
        logic [OFF_W-1:0]   source_offset;
        logic [HADDR_W-1:0] host_address;
        logic [WORD_W-1:0]  host_value;
    } t_instr;

    typedef struct packed {
        logic               wrote_register;
        logic [INDEX_W-1:0] write_index;
        logic [WORD_W-1:0]  write_value;
        logic               address_fault;
    } t_result;

    // Register value (signed) plus sign-extended offset, one bit of headroom
    function automatic logic [WORD_W:0] eff_addr(logic [WORD_W-1:0] base,
                                                 logic [OFF_W-1:0] off);
        logic [WORD_W:0] b;
        logic [WORD_W:0] o;
        b = {base[WORD_W-1], base};
        o = {{(WORD_W+1-OFF_W){off[OFF_W-1]}}, off};
        return b + o;
    endfunction

    // True when a signed address lands inside the data memory
    function automatic logic addr_ok(logic [WORD_W:0] a);
        return !a[WORD_W] && (a[WORD_W-1:0] < WORD_W'(MEMORY_WORDS));
    endfunction

    function automatic logic [MEM_AW-1:0] mem_idx(logic [WORD_W:0] a);
        return a[MEM_AW-1:0];
    endfunction

    // Low bits of a memory index as reported on the result
    function automatic logic [INDEX_W-1:0] out_idx(logic [MEM_AW-1:0] a);
        logic [WORD_W-1:0] w;
        w = WORD_W'(a);
        return w[INDEX_W-1:0];
    endfunction

    function automatic logic [MEM_AW-1:0] host_idx(logic [HADDR_W-1:0] a);
        logic [WORD_W-1:0] w;
        w = WORD_W'(a);
        return w[MEM_AW-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] alu(t_op op, logic [WORD_W-1:0] a,
                                             logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_NOR:  r = ~(a | b);
            OP_XOR:  r = a ^ b;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mtm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable; read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/memory_to_memory_alu_execute_top.sv @@
// Memory-to-memory ALU executor, one instruction per input beat; uses mtm_pkg and mtm_ram.
// Host and store operations write back after the address check; copy, negate and
// load-to-register after one operand read; binary operations and indirect load after a second read.
// The sequencer runs one instruction at a time through the dependent reads of the single
// data memory read port; the input buffer can take the next beat in the meantime.
// Reset clears register valid bits, then zeroes memory a word a cycle (32768), no beat taken.
module memory_to_memory_alu_execute_top
    import mtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] target_reg, [11:3] target_offset, [14:12] source_reg,
    // [23:15] source_offset, [38:24] host_address, [70:39] host_value, [71] zero
    input  logic [71:0] i_s_axis_tdata,
    // [3:0] operation
    input  logic [3:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [14:0] write_index, [46:15] write_value, [47] zero
    output logic [47:0] o_m_axis_tdata,
    // [0] wrote_register, [1] address_fault
    output logic [1:0]  o_m_axis_tuser
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_RDS,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [MEM_AW-1:0]   r_clr;
    logic                r_in_valid;
    t_instr              r_in;
    t_instr              r_cur;
    logic [MEM_AW-1:0]   r_t, n_t;
    logic [WORD_W-1:0]   r_b, n_b;
    logic [WORD_W-1:0]   r_sp;
    logic [REG_COUNT-1:0] r_rv;
    logic                r_ra_v, r_rb_v;
    logic                r_out_valid;
    t_result             r_out;

    logic                in_beat, start, out_free;
    t_op                 cur_op;
    logic                is_bin;

    logic                mem_we, mem_re;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata, mem_q;

    logic                reg_we;
    logic [REG_AW-1:0]   reg_waddr;
    logic [WORD_W-1:0]   reg_wdata, ra_q, rb_q, reg_a, reg_b;

    logic [WORD_W:0]     t_ea, s_ea;
    logic                t_ok, s_ok, sp_ok, p_ok;

    logic                fin, f_fault, f_mem, f_reg, done;
    logic [MEM_AW-1:0]   f_midx;
    logic [REG_AW-1:0]   f_ridx;
    logic [WORD_W-1:0]   f_val;
    t_result             res;

    // Handshake
    assign o_s_axis_tready = !r_in_valid && (r_state != S_CLEAR);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign start           = (r_state == S_IDLE) && r_in_valid;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.write_value, r_out.write_index};
    assign o_m_axis_tuser  = {r_out.address_fault, r_out.wrote_register};

    // Storage: data memory and a duplicated register file (target and source ports)
    mtm_ram #(.WIDTH(WORD_W), .DEPTH(MEMORY_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    mtm_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rega (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_re    (start),
        .i_raddr (r_in.target_reg),
        .o_rdata (ra_q)
    );

    mtm_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_regb (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_re    (start),
        .i_raddr (r_in.source_reg),
        .o_rdata (rb_q)
    );

    // Unwritten registers read as zero
    assign reg_a = r_ra_v ? ra_q : '0;
    assign reg_b = r_rb_v ? rb_q : '0;

    assign cur_op = t_op'(r_cur.operation);
    assign is_bin = (cur_op == OP_ADD) || (cur_op == OP_SUB) || (cur_op == OP_AND) ||
                    (cur_op == OP_OR) || (cur_op == OP_NOR) || (cur_op == OP_XOR);

    // Effective addresses and range checks
    assign t_ea  = eff_addr(reg_a, r_cur.target_offset);
    assign s_ea  = eff_addr(reg_b, r_cur.source_offset);
    assign t_ok  = addr_ok(t_ea);
    assign s_ok  = addr_ok(s_ea);
    assign sp_ok = addr_ok({r_sp[WORD_W-1], r_sp});
    assign p_ok  = addr_ok({mem_q[WORD_W-1], mem_q});

    // Sequencer: register fetch, address check, operand reads, write back
    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_b       = r_b;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        reg_we    = 1'b0;
        reg_waddr = '0;
        reg_wdata = '0;
        fin       = 1'b0;
        f_fault   = 1'b0;
        f_mem     = 1'b0;
        f_reg     = 1'b0;
        f_midx    = r_t;
        f_ridx    = r_cur.target_reg;
        f_val     = '0;
        done      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == MEM_AW'(MEMORY_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_t = mem_idx(t_ea);
                case (cur_op)
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_XOR,
                    OP_COPY, OP_NEGATE, OP_INDIRECT: begin
                        if (!t_ok || !s_ok || (is_bin && !sp_ok)) begin
                            fin     = 1'b1;
                            f_fault = 1'b1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = mem_idx(s_ea);
                            n_state   = S_RDS;
                        end
                    end
                    OP_LOADREG: begin
                        if (!s_ok) begin
                            fin     = 1'b1;
                            f_fault = 1'b1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = mem_idx(s_ea);
                            n_state   = S_RDS;
                        end
                    end
                    OP_STOREREG, OP_STOREADDR: begin
                        fin     = 1'b1;
                        f_fault = !t_ok;
                        f_mem   = t_ok;
                        f_midx  = mem_idx(t_ea);
                        if (cur_op == OP_STOREREG) begin
                            f_val = reg_b;
                        end else begin
                            f_val = reg_b + {{(WORD_W-OFF_W){r_cur.source_offset[OFF_W-1]}},
                                             r_cur.source_offset};
                        end
                    end
                    OP_HOSTMEM: begin
                        fin     = 1'b1;
                        f_fault = !(WORD_W'(r_cur.host_address) < WORD_W'(MEMORY_WORDS));
                        f_mem   = !f_fault;
                        f_midx  = host_idx(r_cur.host_address);
                        f_val   = r_cur.host_value;
                    end
                    OP_HOSTREG: begin
                        fin     = 1'b1;
                        f_fault = !(r_cur.host_address < HADDR_W'(REG_COUNT));
                        f_reg   = !f_fault;
                        f_ridx  = r_cur.host_address[REG_AW-1:0];
                        f_val   = r_cur.host_value;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_RDS: begin
                case (cur_op)
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_XOR: begin
                        n_b       = mem_q;
                        mem_re    = 1'b1;
                        mem_raddr = r_sp[MEM_AW-1:0];
                        n_state   = S_FIN;
                    end
                    OP_INDIRECT: begin
                        if (!p_ok) begin
                            fin     = 1'b1;
                            f_fault = 1'b1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = mem_q[MEM_AW-1:0];
                            n_state   = S_FIN;
                        end
                    end
                    OP_COPY, OP_NEGATE: begin
                        fin   = 1'b1;
                        f_mem = 1'b1;
                        f_val = (cur_op == OP_NEGATE) ? (~mem_q + 1'b1) : mem_q;
                    end
                    OP_LOADREG: begin
                        fin   = 1'b1;
                        f_reg = 1'b1;
                        f_val = mem_q;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_FIN: begin
                fin   = 1'b1;
                f_mem = 1'b1;
                f_val = is_bin ? alu(cur_op, mem_q, r_b) : mem_q;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Commit the single write together with the result beat
        if (fin && out_free) begin
            done      = 1'b1;
            n_state   = S_IDLE;
            mem_we    = f_mem;
            mem_waddr = f_midx;
            mem_wdata = f_val;
            reg_we    = f_reg;
            reg_waddr = f_ridx;
            reg_wdata = f_val;
        end
    end

    // Result word; faults and unused codes report zeros
    always_comb begin
        res                = '0;
        res.address_fault  = f_fault;
        res.wrote_register = f_reg;
        if (f_reg) begin
            res.write_index = INDEX_W'(f_ridx);
            res.write_value = f_val;
        end else if (f_mem) begin
            res.write_index = out_idx(f_midx);
            res.write_value = f_val;
        end
    end

    // State, buffers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_rv        <= '0;
            r_ra_v      <= 1'b0;
            r_rb_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_b     <= n_b;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // Input buffer: fill on a beat, drain when the sequencer starts
            if (in_beat) begin
                r_in_valid         <= 1'b1;
                r_in.operation     <= i_s_axis_tuser;
                r_in.target_reg    <= i_s_axis_tdata[2:0];
                r_in.target_offset <= i_s_axis_tdata[11:3];
                r_in.source_reg    <= i_s_axis_tdata[14:12];
                r_in.source_offset <= i_s_axis_tdata[23:15];
                r_in.host_address  <= i_s_axis_tdata[38:24];
                r_in.host_value    <= i_s_axis_tdata[70:39];
            end else if (start) begin
                r_in_valid <= 1'b0;
            end
            if (start) begin
                r_cur  <= r_in;
                r_ra_v <= r_rv[r_in.target_reg];
                r_rb_v <= r_rv[r_in.source_reg];
            end
            // Register file bookkeeping and stack pointer copy
            if (reg_we) begin
                r_rv[reg_waddr] <= 1'b1;
                if (reg_waddr == REG_AW'(STACK_POINTER_INDEX)) begin
                    r_sp <= reg_wdata;
                end
            end
            // Output register
            if (done) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && reg_we))
        else $error("register and memory written in the same cycle");

    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state != S_CLEAR)) |-> done)
        else $error("memory written without a result beat");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (WORD_W'(mem_waddr) < WORD_W'(MEMORY_WORDS)))
        else $error("memory write outside range");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && res.address_fault) |->
            (!res.wrote_register && (res.write_index == '0) && (res.write_value == '0)))
        else $error("fault result carries write data");

    a_sp_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (reg_we && (reg_waddr == REG_AW'(STACK_POINTER_INDEX))) |=>
            (r_sp == $past(reg_wdata)))
        else $error("stack pointer copy out of step");
`endif

endmodule

@@ dv/mtm_exec_checker.sv @@
`timescale 1ns / 100ps
// Checker for the memory-to-memory ALU executor: watches both stream channels,
// predicts each write from its own register file and data memory, and compares.
// Depends on mtm_pkg for field widths, operation codes and the result layout.
module mtm_exec_checker
    import mtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [2:0] target_reg, [11:3] target_offset, [14:12] source_reg,
    // [23:15] source_offset, [38:24] host_address, [70:39] host_value, [71] zero
    input  logic [71:0] i_s_tdata,
    // [3:0] operation
    input  logic [3:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [14:0] write_index, [46:15] write_value, [47] zero
    input  logic [47:0] i_m_tdata,
    // [0] wrote_register, [1] address_fault
    input  logic [1:0]  i_m_tuser,
    output int          o_pending,
    output int          o_fail_count
);

    logic [WORD_W-1:0] model_regs [REG_COUNT];
    logic [WORD_W-1:0] model_mem  [MEMORY_WORDS];
    t_result           expected_writes [$];

    // Signed register value plus sign-extended offset
    function automatic longint operand_addr(logic [WORD_W-1:0] base, logic [OFF_W-1:0] off);
        return longint'($signed(base)) + longint'($signed(off));
    endfunction

    function automatic bit in_memory(longint a);
        return (a >= 0) && (a < MEMORY_WORDS);
    endfunction

    // Execute one instruction on the model state and return the write it reports
    task automatic execute_model(input logic [3:0] op, input logic [REG_AW-1:0] treg,
                                 input logic [OFF_W-1:0] toff, input logic [REG_AW-1:0] sreg,
                                 input logic [OFF_W-1:0] soff,
                                 input logic [HADDR_W-1:0] haddr,
                                 input logic [WORD_W-1:0] hval, output t_result res);
        longint            t_a;
        longint            s_a;
        longint            sp_a;
        longint            p_a;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] val;
        logic [INDEX_W-1:0] widx;
        bit                fault;
        bit                to_reg;
        bit                writes;
        t_a    = operand_addr(model_regs[treg], toff);
        s_a    = operand_addr(model_regs[sreg], soff);
        sp_a   = operand_addr(model_regs[STACK_POINTER_INDEX], '0);
        fault  = 1'b0;
        to_reg = 1'b0;
        writes = 1'b1;
        val    = '0;
        widx   = '0;
        case (op)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_XOR: begin
                if (!in_memory(t_a) || !in_memory(s_a) || !in_memory(sp_a)) begin
                    fault = 1'b1;
                end else begin
                    a = model_mem[sp_a[MEM_AW-1:0]];
                    b = model_mem[s_a[MEM_AW-1:0]];
                    case (op)
                        OP_ADD:  val = a + b;
                        OP_SUB:  val = a - b;
                        OP_AND:  val = a & b;
                        OP_OR:   val = a | b;
                        OP_NOR:  val = ~(a | b);
                        default: val = a ^ b;
                    endcase
                    widx = t_a[INDEX_W-1:0];
                end
            end
            OP_COPY, OP_NEGATE: begin
                if (!in_memory(t_a) || !in_memory(s_a)) begin
                    fault = 1'b1;
                end else begin
                    val  = model_mem[s_a[MEM_AW-1:0]];
                    if (op == OP_NEGATE) val = -val;
                    widx = t_a[INDEX_W-1:0];
                end
            end
            OP_LOADREG: begin
                if (!in_memory(s_a)) begin
                    fault = 1'b1;
                end else begin
                    val    = model_mem[s_a[MEM_AW-1:0]];
                    to_reg = 1'b1;
                    widx   = INDEX_W'(treg);
                end
            end
            OP_STOREREG, OP_STOREADDR: begin
                if (!in_memory(t_a)) begin
                    fault = 1'b1;
                end else begin
                    val = model_regs[sreg];
                    if (op == OP_STOREADDR) val = val + {{(WORD_W-OFF_W){soff[OFF_W-1]}}, soff};
                    widx = t_a[INDEX_W-1:0];
                end
            end
            OP_INDIRECT: begin
                if (!in_memory(t_a) || !in_memory(s_a)) begin
                    fault = 1'b1;
                end else begin
                    // The pointer word itself must land in memory too
                    p_a = longint'($signed(model_mem[s_a[MEM_AW-1:0]]));
                    if (!in_memory(p_a)) begin
                        fault = 1'b1;
                    end else begin
                        val  = model_mem[p_a[MEM_AW-1:0]];
                        widx = t_a[INDEX_W-1:0];
                    end
                end
            end
            OP_HOSTMEM: begin
                if (!in_memory(longint'(haddr))) begin
                    fault = 1'b1;
                end else begin
                    val  = hval;
                    widx = INDEX_W'(haddr);
                end
            end
            OP_HOSTREG: begin
                if (haddr >= REG_COUNT) begin
                    fault = 1'b1;
                end else begin
                    val    = hval;
                    to_reg = 1'b1;
                    widx   = INDEX_W'(haddr);
                end
            end
            default: writes = 1'b0;
        endcase

        res = '0;
        if (fault) begin
            res.address_fault = 1'b1;
        end else if (writes) begin
            if (to_reg) model_regs[widx[REG_AW-1:0]] = val;
            else        model_mem[widx[MEM_AW-1:0]] = val;
            res.wrote_register = to_reg;
            res.write_index    = widx;
            res.write_value    = val;
        end
    endtask

    // Compare result beats first, then predict the instruction beat of this edge
    always @(posedge i_clk) begin
        t_result exp_res;
        t_result act_res;
        if (!i_rst_n) begin
            foreach (model_regs[i]) model_regs[i] = '0;
            foreach (model_mem[i]) model_mem[i] = '0;
            expected_writes.delete();
            o_fail_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                act_res.wrote_register = i_m_tuser[0];
                act_res.address_fault  = i_m_tuser[1];
                act_res.write_index    = i_m_tdata[14:0];
                act_res.write_value    = i_m_tdata[46:15];
                if (expected_writes.size() == 0) begin
                    $display("%0t: result beat with no instruction pending, actual %h",
                             $time, act_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_writes.pop_front();
                    if (exp_res != act_res) o_fail_count <= o_fail_count + 1;
                    if (exp_res.wrote_register != act_res.wrote_register)
                        $display("%0t: wrote_register mismatch, expected %0d, actual %0d",
                                 $time, exp_res.wrote_register, act_res.wrote_register);
                    if (exp_res.write_index != act_res.write_index)
                        $display("%0t: write_index mismatch, expected %0d, actual %0d",
                                 $time, exp_res.write_index, act_res.write_index);
                    if (exp_res.write_value != act_res.write_value)
                        $display("%0t: write_value mismatch, expected %h, actual %h",
                                 $time, exp_res.write_value, act_res.write_value);
                    if (exp_res.address_fault != act_res.address_fault)
                        $display("%0t: address_fault mismatch, expected %0d, actual %0d",
                                 $time, exp_res.address_fault, act_res.address_fault);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                execute_model(i_s_tuser, i_s_tdata[2:0], i_s_tdata[11:3], i_s_tdata[14:12],
                              i_s_tdata[23:15], i_s_tdata[38:24], i_s_tdata[70:39], exp_res);
                expected_writes.push_back(exp_res);
            end
        end
        o_pending <= expected_writes.size();
    end

endmodule

@@ dv/tb_memory_to_memory_alu_execute_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the memory-to-memory ALU executor: clock, reset, instruction
// stimulus, result back-pressure and verdict. Depends on mtm_pkg and mtm_exec_checker.
module tb_memory_to_memory_alu_execute_top;
    import mtm_pkg::*;

    localparam int ITEMS_PER_PHASE = 512;
    localparam int LIMIT_CYCLES    = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count = 0;

    always #6 i_clk = ~i_clk;

    memory_to_memory_alu_execute_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    mtm_exec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Throttle result beats at the current stall rate
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_memory_to_memory_alu_execute_top: FAIL");
            $finish;
        end
    end

    // Drive one instruction beat, with random idle cycles ahead of it
    task automatic issue(input logic [3:0] op, input logic [2:0] treg, input logic [8:0] toff,
                         input logic [2:0] sreg, input logic [8:0] soff,
                         input logic [14:0] haddr, input logic [31:0] hval);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, hval, haddr, soff, sreg, toff, treg};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int          pick;
        logic [3:0]  op;
        logic [14:0] haddr;
        logic [31:0] hval;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        m_tready      <= 1'b0;
        i_rst_n       <= 1'b0;
        send_idle_pct  = 24;
        recv_idle_pct  = 59;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: base registers (r1 stack pointer, r2 mid, r3 near top, r4 zero)
        issue(OP_HOSTREG, 3'd7, 9'h1FF, 3'd7, 9'h1FF, 15'd1, 32'd1000);
        issue(OP_HOSTREG, 3'd0, 9'h000, 3'd0, 9'h000, 15'd2, 32'd1100);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd3, 32'd32512);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd4, 32'd0);
        // Preload stack top, operands, the last word and a pointer
        issue(OP_HOSTMEM, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd1000, 32'h7FFF_FFFF);
        issue(OP_HOSTMEM, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd844, 32'h8000_0000);
        issue(OP_HOSTMEM, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd32767, 32'hFFFF_FFFF);
        issue(OP_HOSTMEM, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd1105, 32'd1000);
        // Binary ops against the stack top; 9'h100 is offset -256, 9'h0FF is +255
        issue(OP_ADD, 3'd2, 9'h0FF, 3'd2, 9'h100, 15'($urandom), $urandom);
        issue(OP_SUB, 3'd2, 9'h0FE, 3'd2, 9'h100, 15'($urandom), $urandom);
        issue(OP_AND, 3'd2, 9'h0FD, 3'd3, 9'h0FF, 15'($urandom), $urandom);
        issue(OP_OR,  3'd2, 9'h0FC, 3'd2, 9'h100, 15'($urandom), $urandom);
        issue(OP_NOR, 3'd2, 9'h0FB, 3'd4, 9'h000, 15'($urandom), $urandom);
        issue(OP_XOR, 3'd2, 9'h0FA, 3'd3, 9'h0FF, 15'($urandom), $urandom);
        // Copy into the last word, negate the most negative word
        issue(OP_COPY,   3'd3, 9'h0FF, 3'd2, 9'h100, 15'($urandom), $urandom);
        issue(OP_NEGATE, 3'd4, 9'h000, 3'd2, 9'h100, 15'($urandom), $urandom);
        issue(OP_LOADREG,  3'd7, 9'($urandom), 3'd3, 9'h0FF, 15'($urandom), $urandom);
        issue(OP_STOREREG, 3'd4, 9'h001, 3'd7, 9'($urandom), 15'($urandom), $urandom);
        // Store address wrapping below zero and above all ones
        issue(OP_STOREADDR, 3'd4, 9'h002, 3'd4, 9'h100, 15'($urandom), $urandom);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd6, 32'hFFFF_FFFF);
        issue(OP_STOREADDR, 3'd4, 9'h003, 3'd6, 9'h0FF, 15'($urandom), $urandom);
        // Indirect load through a good pointer, then through a negative one
        issue(OP_INDIRECT, 3'd2, 9'h002, 3'd2, 9'h005, 15'($urandom), $urandom);
        issue(OP_INDIRECT, 3'd2, 9'h003, 3'd2, 9'h100, 15'($urandom), $urandom);
        // Faults: target below zero, source past the top, stack pointer invalid
        issue(OP_COPY, 3'd4, 9'h1FF, 3'd2, 9'h000, 15'($urandom), $urandom);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd5, 32'd32767);
        issue(OP_NEGATE, 3'd2, 9'h000, 3'd5, 9'h001, 15'($urandom), $urandom);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd1, 32'hFFFF_FFFF);
        issue(OP_XOR, 3'd2, 9'h000, 3'd2, 9'h000, 15'($urandom), $urandom);
        // Host register index out of range, and the unused operation codes
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'd8, $urandom);
        issue(OP_HOSTREG, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'h7FFF, $urandom);
        issue(4'd14, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'($urandom), $urandom);
        issue(4'd15, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom),
              15'($urandom), $urandom);

        // Random phases: sender idles lightly, then heavily, then neither idles
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick  = $urandom_range(99);
                haddr = 15'($urandom);
                hval  = $urandom;
                if (pick < 12) begin
                    // Keep base registers mostly in the working region near 1000
                    op = OP_HOSTREG;
                    if ($urandom_range(99) < 90) haddr = 15'($urandom_range(7));
                    case ($urandom_range(9))
                        0:       hval = $urandom_range(20);
                        1:       hval = $urandom_range(32767, 32500);
                        2:       hval = $urandom;
                        default: hval = $urandom_range(1250, 900);
                    endcase
                end else if (pick < 27) begin
                    // Fill the working region with data, pointers and extremes
                    op = OP_HOSTMEM;
                    if ($urandom_range(99) < 70) haddr = 15'($urandom_range(1500, 700));
                    case ($urandom_range(4))
                        0, 1:    hval = $urandom_range(1500, 700);
                        2:       hval = {1'($urandom_range(1)), {31{$urandom_range(1) == 1}}};
                        default: hval = $urandom;
                    endcase
                end else if (pick < 31) begin
                    op = 4'($urandom);
                end else begin
                    op = 4'($urandom_range(11));
                end
                issue(op, 3'($urandom), 9'($urandom), 3'($urandom), 9'($urandom), haddr, hval);
            end
        end

        // Let the last results land, then report
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_memory_to_memory_alu_execute_top: PASS");
        end else begin
            $display("tb_memory_to_memory_alu_execute_top: FAIL");
        end
        $finish;
    end

endmodule
